// ===== src/poly1305_mac_assert.svh =====
// Assertion macros for the port checker file
`ifndef POLY1305_MAC_ASSERT_SVH
`define POLY1305_MAC_ASSERT_SVH

// Assertion that is not evaluated while reset is low
`define P1305_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("p1305 check failed");

// Assertion that is also evaluated during reset
`define P1305_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("p1305 reset check failed");

`endif

// ===== src/p1305_pkg.sv =====
// Shared types and constants for the Poly1305 authenticator
package p1305_pkg;

    localparam int LIMB_W  = 26;
    localparam int ACC_W   = 27;
    localparam int COL_W   = 64;
    localparam int KEY_W   = 64;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    localparam logic [63:0] CLAMP_LO = 64'h0FFF_FFFC_0FFF_FFFF;
    localparam logic [63:0] CLAMP_HI = 64'h0FFF_FFFC_0FFF_FFFC;
    localparam logic [4:0]  FULL_CNT = 5'd16;

    typedef enum logic [1:0] {
        REG_R_LO = 2'd0,
        REG_R_HI = 2'd1,
        REG_S_LO = 2'd2,
        REG_S_HI = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic        we;
        t_reg_idx    index;
        logic [63:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        hibit;
        logic        absorb;
        logic        fin;
    } t_blk;

endpackage

// ===== src/p1305_if.sv =====
// Valid/ready channel interfaces for message words and tag words
interface p1305_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_low;
    logic [63:0] message_high;
    logic [4:0]  byte_count;
    logic        last;

    modport source (output valid, message_low, message_high, byte_count, last, input ready);
    modport sink   (input valid, message_low, message_high, byte_count, last, output ready);
endinterface

interface p1305_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] tag_low;
    logic [63:0] tag_high;

    modport source (output valid, tag_low, tag_high, input ready);
    modport sink   (input valid, tag_low, tag_high, output ready);
endinterface

// ===== src/poly1305_mac.sv =====
// Top level of the Poly1305 authenticator
//  channel   dir  handshake           word
//  i_msg     in   valid/ready         message_low, message_high, byte_count, last
//  o_tag     out  valid/ready         tag_low, tag_high
//  i_cfg_*   in   write enable only   index 0..3, 64-bit data
// A block goes through the multiply-accumulate loop as products (S_RUN), then carry
// fold (S_ACC); each block depends on the previous accumulator, so the next waits.
// A closing word adds final reduction (S_FIN), then S_TAG loads the tag register.
// The two-entry queue takes words while the back end works or the tag waits.
// Reset is synchronous; no clearing pass is needed.
module poly1305_mac (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    p1305_in_if.sink    i_msg,
    p1305_out_if.source o_tag
);
    import p1305_pkg::*;

    t_cfg_wr cfg;
    logic    q_valid, q_pop;
    t_blk    q_data;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = t_reg_idx'(i_cfg_index);
    assign cfg.data  = i_cfg_data;

    p1305_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_msg     (i_msg),
        .o_q_valid (q_valid),
        .o_q_data  (q_data),
        .i_q_pop   (q_pop)
    );

    p1305_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_tag     (o_tag)
    );
endmodule

// ===== src/p1305_front.sv =====
// Front end: accept message words, pad and classify, two-entry queue
module p1305_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    p1305_in_if.sink        i_msg,
    output logic            o_q_valid,
    output p1305_pkg::t_blk o_q_data,
    input  logic            i_q_pop
);
    import p1305_pkg::*;

    t_blk                 r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wp, r_rp;
    logic [Q_PTR_W:0]     r_cnt;
    t_blk                 n_blk;
    logic                 push;
    logic                 full;
    logic [6:0]           sh;
    logic [127:0]         msg, one, padded;

    assign i_msg.ready = (r_cnt != (Q_PTR_W+1)'(Q_DEPTH));
    assign push        = i_msg.valid && i_msg.ready;
    assign o_q_valid   = (r_cnt != '0);
    assign o_q_data    = r_q[r_rp];

    always_comb begin
        full   = (i_msg.byte_count >= FULL_CNT);
        sh     = {i_msg.byte_count[3:0], 3'b000};
        msg    = {i_msg.message_high, i_msg.message_low};
        one    = 128'd1 << sh;
        padded = full ? msg : ((msg & (one - 128'd1)) | one);
        n_blk.lo     = padded[63:0];
        n_blk.hi     = padded[127:64];
        n_blk.hibit  = full;
        n_blk.absorb = full || (i_msg.byte_count != '0);
        n_blk.fin    = i_msg.last || !full;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(i_q_pop);
        end
    end
endmodule

// ===== src/p1305_back.sv =====
// Back end: key registers, multiply-accumulate mod 2^130-5, tag output
module p1305_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  p1305_pkg::t_cfg_wr i_cfg,
    input  logic               i_q_valid,
    input  p1305_pkg::t_blk    i_q_data,
    output logic               o_q_pop,
    p1305_out_if.source        o_tag
);
    import p1305_pkg::*;

    typedef enum logic [3:0] {
        S_RUN = 4'b0001,
        S_ACC = 4'b0010,
        S_FIN = 4'b0100,
        S_TAG = 4'b1000
    } t_state;

    t_state               r_st, n_st;
    logic [KEY_W-1:0]     r_rk_lo, r_rk_hi, r_sk_lo, r_sk_hi;
    logic [ACC_W-1:0]     r_h [5];
    logic [COL_W-1:0]     r_d [5];
    logic                 r_fin;
    logic [130:0]         r_v;
    logic                 r_ov;
    logic [127:0]         r_tag;

    logic [129:0]         rc;
    logic [127:0]         nm;
    logic [LIMB_W-1:0]    rl [5];
    logic [LIMB_W+2:0]    rr [5][5];
    logic [ACC_W:0]       a [5];
    logic [ACC_W:0]       nl [5];
    logic [COL_W-1:0]     n_d [5];
    logic [COL_W-1:0]     dc [5];
    logic [COL_W-1:0]     c;
    logic [ACC_W-1:0]     n_h [5];
    logic [131:0]         v;
    logic [130:0]         v2, g;
    logic [127:0]         sel;
    logic                 out_free;

    always_comb begin
        rc = {2'b00, r_rk_hi & CLAMP_HI, r_rk_lo & CLAMP_LO};
        nm = {i_q_data.hi, i_q_data.lo};
        for (int i = 0; i < 5; i++) begin
            rl[i] = rc[i*LIMB_W +: LIMB_W];
        end
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) begin
                if (j <= i) begin
                    rr[i][j] = (LIMB_W+3)'(rl[i-j]);
                end else begin
                    rr[i][j] = (LIMB_W+3)'(rl[i-j+5]) * (LIMB_W+3)'(5);
                end
            end
        end
        for (int i = 0; i < 4; i++) begin
            nl[i] = (ACC_W+1)'(nm[i*LIMB_W +: LIMB_W]);
        end
        nl[4] = (ACC_W+1)'({i_q_data.hibit, nm[127:104]});
        for (int i = 0; i < 5; i++) begin
            a[i] = (ACC_W+1)'(r_h[i]) + nl[i];
        end
        for (int i = 0; i < 5; i++) begin
            n_d[i] = '0;
            for (int j = 0; j < 5; j++) begin
                n_d[i] = n_d[i] + COL_W'((ACC_W+LIMB_W+4)'(a[j])
                                         * (ACC_W+LIMB_W+4)'(rr[i][j]));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            dc[i] = r_d[i];
        end
        for (int i = 0; i < 4; i++) begin
            n_h[i]    = ACC_W'(dc[i][LIMB_W-1:0]);
            dc[i+1]   = dc[i+1] + (dc[i] >> LIMB_W);
        end
        n_h[4] = ACC_W'(dc[4][LIMB_W-1:0]);
        c      = (dc[4] >> LIMB_W) * COL_W'(5) + COL_W'(n_h[0]);
        n_h[0] = ACC_W'(c[LIMB_W-1:0]);
        n_h[1] = n_h[1] + ACC_W'(c >> LIMB_W);
    end

    always_comb begin
        v = 132'(r_h[0]) + (132'(r_h[1]) << 26) + (132'(r_h[2]) << 52)
          + (132'(r_h[3]) << 78) + (132'(r_h[4]) << 104);
        v2  = 131'(v[129:0]) + 131'(v[131:130]) * 131'(5);
        g   = r_v + 131'(5);
        sel = g[130] ? g[127:0] : r_v[127:0];
    end

    assign out_free    = !r_ov || o_tag.ready;
    assign o_tag.valid = r_ov;
    assign o_tag.tag_low  = r_tag[63:0];
    assign o_tag.tag_high = r_tag[127:64];
    assign o_q_pop     = (r_st == S_RUN) && i_q_valid;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_RUN: begin
                if (i_q_valid) begin
                    n_st = i_q_data.absorb ? S_ACC : S_FIN;
                end
            end
            S_ACC: n_st = r_fin ? S_FIN : S_RUN;
            S_FIN: n_st = S_TAG;
            S_TAG: begin
                if (out_free) begin
                    n_st = S_RUN;
                end
            end
            default: n_st = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_d   <= n_d;
            r_fin <= i_q_data.fin;
        end
        if (r_st == S_FIN) begin
            r_v <= v2;
        end
        if (r_st == S_TAG && out_free) begin
            r_tag <= sel + {r_sk_hi, r_sk_lo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_RUN;
            r_ov    <= 1'b0;
            r_rk_lo <= '0;
            r_rk_hi <= '0;
            r_sk_lo <= '0;
            r_sk_hi <= '0;
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (i_cfg.we) begin
                unique case (i_cfg.index)
                    REG_R_LO: r_rk_lo <= i_cfg.data;
                    REG_R_HI: r_rk_hi <= i_cfg.data;
                    REG_S_LO: r_sk_lo <= i_cfg.data;
                    REG_S_HI: r_sk_hi <= i_cfg.data;
                    default:  r_sk_hi <= r_sk_hi;
                endcase
            end
            if (r_st == S_ACC) begin
                r_h <= n_h;
            end else if (r_st == S_FIN) begin
                for (int i = 0; i < 5; i++) begin
                    r_h[i] <= '0;
                end
            end
            if (r_st == S_TAG && out_free) begin
                r_ov <= 1'b1;
            end else if (o_tag.ready) begin
                r_ov <= 1'b0;
            end
        end
    end
endmodule

// ===== src/p1305_chk.sv =====
// Port checker for the Poly1305 authenticator and its bind
`include "poly1305_mac_assert.svh"

module p1305_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [127:0] i_out_tag
);
    `P1305_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid)
    `P1305_ASSERT(a_tag_hold, i_out_valid && !i_out_ready |=> $stable(i_out_tag))
    `P1305_ASSERT_RST(a_rst_out, !i_rst_n |=> !i_out_valid)
    `P1305_ASSERT_RST(a_rst_rdy, !i_rst_n |=> i_in_ready)
endmodule

bind poly1305_mac p1305_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_msg.ready),
    .i_out_valid (o_tag.valid),
    .i_out_ready (o_tag.ready),
    .i_out_tag   ({o_tag.tag_high, o_tag.tag_low})
);

// ===== tb/testbench.sv =====
// Testbench for the Poly1305 authenticator: directed table plus random messages
`timescale 1ns / 100ps

module testbench;
    import p1305_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          LONG_HOLD      = 200;
    localparam int          ITEM_TARGET    = 1200;
    localparam logic [130:0] PRIME         = (131'd1 << 130) - 131'd5;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  cnt;
        logic        last;
        logic        typed;
    } t_row;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_tag;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    p1305_in_if  msg_if ();
    p1305_out_if tag_if ();

    poly1305_mac i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_msg       (msg_if.sink),
        .o_tag       (tag_if.source)
    );

    always #6 i_clk = ~i_clk;

    logic [63:0]  key_r_lo = '0, key_r_hi = '0, key_s_lo = '0, key_s_hi = '0;
    logic [130:0] acc_value = '0;
    t_tag         tag_queue[$];
    int           mismatches = 0;
    int           words_sent = 0;
    int           idle_cycles = 0;
    bit           quiet = 1'b0;
    bit           hold_req = 1'b0;
    bit           hold_done = 1'b0;
    bit           cur_typed = 1'b0;

    // Absorb one word into the accumulator; return 1 with the tag if the message ends.
    function automatic bit mac_word(input logic [63:0] lo, input logic [63:0] hi,
                                    input logic [4:0] cnt, input logic last,
                                    output t_tag tag);
        logic [128:0] blk;
        logic [127:0] data;
        logic [263:0] prod;
        logic [127:0] r;
        logic [127:0] sum;
        bit           ends;
        ends = last;
        data = {hi, lo};
        r = {key_r_hi & CLAMP_HI, key_r_lo & CLAMP_LO};
        if (cnt >= FULL_CNT) begin
            blk = {1'b1, data};
        end else begin
            ends = 1'b1;
            blk = '0;
            for (int b = 0; b < 16; b++)
                if (b < cnt)
                    blk[8*b +: 8] = data[8*b +: 8];
            blk[8*cnt] = 1'b1;
        end
        if (cnt != 5'd0) begin
            prod = (264'(acc_value) + 264'(blk)) * 264'(r);
            acc_value = 131'(prod % 264'(PRIME));
        end
        if (ends) begin
            sum = 128'(acc_value % PRIME) + {key_s_hi, key_s_lo};
            tag.lo = sum[63:0];
            tag.hi = sum[127:64];
            acc_value = '0;
        end
        return ends;
    endfunction

    always @(posedge i_clk) begin
        t_tag tag;
        t_tag got;
        bit   accepted;
        accepted = 1'b0;
        if (i_rst_n && msg_if.valid && msg_if.ready) begin
            accepted = 1'b1;
            if (mac_word(msg_if.message_low, msg_if.message_high, msg_if.byte_count,
                         msg_if.last, tag)) begin
                if (cur_typed)
                    tag = '{lo: 64'd0, hi: 64'd0};
                tag_queue.push_back(tag);
            end
        end
        if (i_rst_n && tag_if.valid && tag_if.ready) begin
            accepted = 1'b1;
            got = '{lo: tag_if.tag_low, hi: tag_if.tag_high};
            if (tag_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected tag %h_%h", got.hi, got.lo);
            end else begin
                tag = tag_queue.pop_front();
                if (got.lo !== tag.lo || got.hi !== tag.hi) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tag mismatch: expected %h_%h got %h_%h",
                                 tag.hi, tag.lo, got.hi, got.lo);
                end
            end
        end
        idle_cycles = accepted ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        tag_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                tag_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_done = 1'b1;
                tag_if.ready <= 1'b1;
            end else if (!quiet && $urandom_range(5) == 0) begin
                tag_if.ready <= 1'b0;
                repeat ($urandom_range(3, 1) - 1) @(negedge i_clk);
            end else begin
                tag_if.ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(input t_reg_idx idx, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        case (idx)
            REG_R_LO: key_r_lo = value;
            REG_R_HI: key_r_hi = value;
            REG_S_LO: key_s_lo = value;
            default:  key_s_hi = value;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_key(input logic [63:0] rl, input logic [63:0] rh,
                           input logic [63:0] sl, input logic [63:0] sh);
        while (tag_queue.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        cfg_write(REG_R_LO, rl);
        cfg_write(REG_R_HI, rh);
        cfg_write(REG_S_LO, sl);
        cfg_write(REG_S_HI, sh);
    endtask

    task automatic send_word(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] cnt, input logic last, input bit typed);
        if (!quiet && $urandom_range(4) == 0) begin
            msg_if.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        msg_if.valid <= 1'b1;
        msg_if.message_low <= lo;
        msg_if.message_high <= hi;
        msg_if.byte_count <= cnt;
        msg_if.last <= last;
        cur_typed <= typed;
        do @(posedge i_clk); while (!(msg_if.valid && msg_if.ready));
        @(negedge i_clk);
        words_sent++;
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    t_row table_rows[] = '{
        '{64'h0, 64'h0, 5'd0, 1'b1, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 1'b1, 1'b1},
        '{64'h0, 64'h0, 5'd16, 1'b1, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 1'b0, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd15, 1'b0, 1'b1},
        '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd1, 1'b1, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd7, 1'b0, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd8, 1'b1, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd9, 1'b1, 1'b1},
        '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 5'd17, 1'b0, 1'b0},
        '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 5'd31, 1'b1, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 5'd16, 1'b0, 1'b0},
        '{64'h0, 64'h0, 5'd0, 1'b0, 1'b1},
        '{64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 5'd16, 1'b0, 1'b0},
        '{64'h1, 64'h0, 5'd16, 1'b0, 1'b0},
        '{64'hDEAD_BEEF_0000_0000, 64'h0, 5'd12, 1'b0, 1'b1}
    };

    initial begin
        int nblk;
        msg_if.valid = 1'b0;
        msg_if.message_low = '0;
        msg_if.message_high = '0;
        msg_if.byte_count = '0;
        msg_if.last = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero key: every tag is zero.
        foreach (table_rows[k])
            send_word(table_rows[k].lo, table_rows[k].hi, table_rows[k].cnt,
                      table_rows[k].last, table_rows[k].typed);
        msg_if.valid <= 1'b0;
        cur_typed <= 1'b0;
        set_key('1, '1, '1, '1);
        foreach (table_rows[k])
            send_word(table_rows[k].lo, table_rows[k].hi, table_rows[k].cnt,
                      table_rows[k].last, 1'b0);
        msg_if.valid <= 1'b0;

        while (words_sent < ITEM_TARGET) begin
            if ($urandom_range(60) == 0) begin
                msg_if.valid <= 1'b0;
                set_key(rand64(), rand64(), rand64(), rand64());
            end
            if (words_sent > 300) hold_req = 1'b1;
            if (words_sent > ITEM_TARGET - 150) quiet = 1'b1;
            if ($urandom_range(7) == 0) begin
                send_word(rand64(), rand64(), 5'($urandom_range(31)), 1'($urandom), 1'b0);
            end else begin
                nblk = $urandom_range(6);
                repeat (nblk)
                    send_word(rand64(), rand64(), FULL_CNT, 1'b0, 1'b0);
                if ($urandom_range(1))
                    send_word(rand64(), rand64(), FULL_CNT, 1'b1, 1'b0);
                else
                    send_word(rand64(), rand64(), 5'($urandom_range(15)),
                              1'($urandom), 1'b0);
            end
        end
        msg_if.valid <= 1'b0;

        while (tag_queue.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
